// File: hdl/mer_pkg.sv
`default_nettype none

package mer_pkg;

  // Field widths
  localparam int AXIS_BITS  = 11;
  localparam int COORD_BITS = 16;
  localparam int COLOR_BITS = 24;

  // Step counters: x saturates one bit wider than the axis, y counts down from b
  localparam int STEP_X_W = AXIS_BITS + 1;

  // Datapath widths
  localparam int ASQ_W  = 2 * AXIS_BITS;      // a*a, b*b
  localparam int QP_W   = 3 * AXIS_BITS + 1;  // B*(x+1), A*(2y-1)
  localparam int OPA_W  = 3 * AXIS_BITS + 2;  // multiplier operand A
  localparam int OPB_W  = 2 * AXIS_BITS;      // multiplier operand B
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int TMP_W  = 4 * AXIS_BITS + 4;  // widest product actually reached
  localparam int DEC_W  = (4 * AXIS_BITS + 8 < 64) ? 4 * AXIS_BITS + 8 : 64;

  // Stream packing
  localparam int IN_FIELDS_W  = 2 * AXIS_BITS + 2 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [AXIS_BITS-1:0]         axis_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Multiplier operand pairs; the product lands in the matching register
  typedef enum logic [2:0] {
    MUL_AA      = 3'd0,  // a*a           -> A
    MUL_BB      = 3'd1,  // b*b           -> B
    MUL_AB      = 3'd2,  // A*b           -> temp
    MUL_BX1     = 3'd3,  // B*(x+1)       -> q
    MUL_AY      = 3'd4,  // A*(2y-1)      -> p
    MUL_BXX     = 3'd5,  // B(2x+1)*(2x+1) -> temp
    MUL_AYY     = 3'd6,  // A(y-1)*(y-1)  -> temp
    MUL_ASQ_BSQ = 3'd7   // A*B           -> temp
  } mul_sel_t;

  typedef enum logic [2:0] {
    DEC_HOLD      = 3'd0,
    DEC_INIT      = 3'd1,
    DEC_LOAD_T    = 3'd2,
    DEC_ADD_4T    = 3'd3,
    DEC_SUB_4T    = 3'd4,
    DEC_ADD_DELTA = 3'd5
  } dec_op_t;

  typedef struct packed {
    logic     load;        // capture a start request
    logic     mul_en;
    mul_sel_t mul_sel;
    dec_op_t  dec_op;
    logic     calc_delta;  // form the step increment and step flags
    logic     set_r2;      // enter region two
    logic     step;        // apply step flags to x and y
    logic     emit;        // load the result register with the point
    logic     emit_zero;   // load the result register with an empty result
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic in_region_two;
    logic region_one;      // 2B(x+1) < A(2y-1)
    logic step_y_zero;
  } dp_status_t;

  typedef struct packed {
    axis_t  semi_axis_x;
    axis_t  semi_axis_y;
    coord_t center_x;
    coord_t center_y;
    color_t color;
  } in_item_t;

  typedef struct packed {
    coord_t x_plus;
    coord_t x_minus;
    coord_t y_plus;
    coord_t y_minus;
    color_t pixel_color;
    logic   valid_res;
    logic   last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/mer_dp.sv
`default_nettype none

module mer_dp import mer_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  in_item_t   item,
  output dp_status_t status,
  output res_t       res
);

  localparam int SUM_W = ((COORD_BITS > STEP_X_W + 1) ? COORD_BITS : STEP_X_W + 1) + 1;
  localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CMIN = SUM_W'(-(1 << (COORD_BITS - 1)));

  axis_t                a_r, b_r;
  logic [ASQ_W-1:0]     asq_r, bsq_r;
  logic [QP_W-1:0]      q_r, p_r;
  logic [TMP_W-1:0]     t_r;
  logic [DEC_W-1:0]     dec_r, delta_r;
  logic [DEC_W-1:0]     dec_nxt, delta_nxt;
  logic [STEP_X_W-1:0]  sx_r, sx_nxt;
  axis_t                sy_r, sy_nxt;
  coord_t               cx_r, cy_r;
  color_t               color_r;
  logic                 r2_r, busy_r, inc_x_r, dec_y_r;

  logic [OPA_W-1:0]     op_a;
  logic [OPB_W-1:0]     op_b;
  logic [PROD_W-1:0]    prod;

  logic [STEP_X_W:0]    x_p1, x2p1;
  logic [AXIS_BITS:0]   y2m1;
  axis_t                y_m1;
  logic [OPA_W-1:0]     bx2p1;
  logic [QP_W-1:0]      pa;
  logic                 d_neg;
  logic [DEC_W-1:0]     a_e, b_e, q_e, p_e, t_e;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    if (v > CMAX) begin
      sat_coord = COORD_BITS'(CMAX);
    end else if (v < CMIN) begin
      sat_coord = COORD_BITS'(CMIN);
    end else begin
      sat_coord = COORD_BITS'(v);
    end
  endfunction

  // Step-dependent multiplier terms
  assign x_p1  = (STEP_X_W + 1)'(sx_r) + (STEP_X_W + 1)'(1);
  assign x2p1  = {sx_r, 1'b1};
  assign y2m1  = {sy_r, 1'b0} - (AXIS_BITS + 1)'(1);
  assign y_m1  = sy_r - AXIS_BITS'(1);
  assign bx2p1 = {q_r, 1'b0} - OPA_W'(bsq_r);   // B(2x+1)
  assign pa    = p_r - QP_W'(asq_r);            // 2A(y-1)

  // Select multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_AA: begin
        op_a = OPA_W'(a_r);
        op_b = OPB_W'(a_r);
      end
      MUL_BB: begin
        op_a = OPA_W'(b_r);
        op_b = OPB_W'(b_r);
      end
      MUL_AB: begin
        op_a = OPA_W'(asq_r);
        op_b = OPB_W'(b_r);
      end
      MUL_BX1: begin
        op_a = OPA_W'(bsq_r);
        op_b = OPB_W'(x_p1);
      end
      MUL_AY: begin
        op_a = OPA_W'(asq_r);
        op_b = OPB_W'(y2m1);
      end
      MUL_BXX: begin
        op_a = bx2p1;
        op_b = OPB_W'(x2p1);
      end
      MUL_AYY: begin
        op_a = OPA_W'(pa[QP_W-1:1]);
        op_b = OPB_W'(y_m1);
      end
      MUL_ASQ_BSQ: begin
        op_a = OPA_W'(asq_r);
        op_b = OPB_W'(bsq_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // Register the product in its destination
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_AA:  asq_r <= ASQ_W'(prod);
        MUL_BB:  bsq_r <= ASQ_W'(prod);
        MUL_BX1: q_r   <= QP_W'(prod);
        MUL_AY:  p_r   <= QP_W'(prod);
        default: t_r   <= TMP_W'(prod);
      endcase
    end
  end

  // Decision update, scaled by four and wrapping at its width
  assign a_e   = DEC_W'(asq_r);
  assign b_e   = DEC_W'(bsq_r);
  assign q_e   = DEC_W'(q_r);
  assign p_e   = DEC_W'(p_r);
  assign t_e   = DEC_W'(t_r);
  assign d_neg = dec_r[DEC_W-1];

  always_comb begin
    case (cmd.dec_op)
      DEC_INIT:      dec_nxt = (b_e << 2) + a_e - (t_e << 2);
      DEC_LOAD_T:    dec_nxt = t_e;
      DEC_ADD_4T:    dec_nxt = dec_r + (t_e << 2);
      DEC_SUB_4T:    dec_nxt = dec_r - (t_e << 2);
      DEC_ADD_DELTA: dec_nxt = dec_r + delta_r;
      default:       dec_nxt = dec_r;
    endcase
  end

  // Region one: 4B(2x+3), less 8A(y-1) when d >= 0.
  // Region two: 12A - 8Ay, plus 4B(2x+2) when d < 0.
  always_comb begin
    if (r2_r) begin
      delta_nxt = (d_neg ? (q_e << 3) : '0) - (p_e << 2) + (a_e << 3);
    end else begin
      delta_nxt = (q_e << 3) + (b_e << 2) - (d_neg ? '0 : ((p_e << 2) - (a_e << 2)));
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    if (cmd.calc_delta) begin
      delta_r <= delta_nxt;
      inc_x_r <= r2_r ? d_neg : 1'b1;
      dec_y_r <= r2_r ? 1'b1 : !d_neg;
    end
  end

  // Next step position; x holds at its maximum
  assign sx_nxt = (cmd.step && inc_x_r && !(&sx_r)) ? sx_r + STEP_X_W'(1) : sx_r;
  assign sy_nxt = (cmd.step && dec_y_r) ? y_m1 : sy_r;

  // Hold ellipse parameters and position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= item.semi_axis_x;
      b_r     <= item.semi_axis_y;
      cx_r    <= item.center_x;
      cy_r    <= item.center_y;
      color_r <= item.color;
      sx_r    <= '0;
      sy_r    <= item.semi_axis_y;
    end else if (cmd.step) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
  end

  // Track the active ellipse and its region
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      r2_r   <= 1'b0;
    end else if (cmd.load) begin
      busy_r <= 1'b1;
      r2_r   <= 1'b0;
    end else begin
      if (cmd.set_r2) begin
        r2_r <= 1'b1;
      end
      if ((cmd.emit && sy_nxt == '0) || cmd.emit_zero) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign status.busy          = busy_r;
  assign status.in_region_two = r2_r;
  assign status.region_one    = ({q_r, 1'b0} < {1'b0, p_r});
  assign status.step_y_zero   = (sy_r == '0);

  // Mirror the point around the center
  assign res.x_plus  = sat_coord($signed({{(SUM_W - COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r})
                               + $signed({{(SUM_W - STEP_X_W){1'b0}}, sx_nxt}));
  assign res.x_minus = sat_coord($signed({{(SUM_W - COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r})
                               - $signed({{(SUM_W - STEP_X_W){1'b0}}, sx_nxt}));
  assign res.y_plus  = sat_coord($signed({{(SUM_W - COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r})
                               + $signed({{(SUM_W - AXIS_BITS){1'b0}}, sy_nxt}));
  assign res.y_minus = sat_coord($signed({{(SUM_W - COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r})
                               - $signed({{(SUM_W - AXIS_BITS){1'b0}}, sy_nxt}));
  assign res.pixel_color = color_r;
  assign res.valid_res   = 1'b1;
  assign res.last        = (sy_nxt == '0);

endmodule

`default_nettype wire

// File: hdl/mer_ctrl.sv
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_op,
  input  dp_status_t status,
  input  logic       out_free,
  output dp_cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_ST1  = 14'b00000000000010,
    S_ST2  = 14'b00000000000100,
    S_ST3  = 14'b00000000001000,
    S_ST4  = 14'b00000000010000,
    S_A1   = 14'b00000000100000,
    S_A2   = 14'b00000001000000,
    S_A3   = 14'b00000010000000,
    S_E1   = 14'b00000100000000,
    S_E2   = 14'b00001000000000,
    S_E3   = 14'b00010000000000,
    S_E4   = 14'b00100000000000,
    S_A4   = 14'b01000000000000,
    S_ZERO = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Sequence the shared multiplier and the decision accumulator
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (op_t'(in_op))
            OP_START: begin
              cmd.load  = 1'b1;
              state_nxt = S_ST1;
            end
            OP_ADVANCE: begin
              state_nxt = (status.busy && !status.step_y_zero) ? S_A1 : S_ZERO;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ST1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA;
        state_nxt   = S_ST2;
      end
      S_ST2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BB;
        state_nxt   = S_ST3;
      end
      S_ST3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AB;
        state_nxt   = S_ST4;
      end
      S_ST4: begin
        if (out_free) begin
          cmd.dec_op = DEC_INIT;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_A1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BX1;
        state_nxt   = S_A2;
      end
      S_A2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AY;
        state_nxt   = S_A3;
      end
      S_A3: begin
        if (status.in_region_two || status.region_one) begin
          cmd.calc_delta = 1'b1;
          state_nxt      = S_A4;
        end else begin
          cmd.set_r2 = 1'b1;
          state_nxt  = S_E1;
        end
      end
      S_E1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BXX;
        state_nxt   = S_E2;
      end
      S_E2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AYY;
        cmd.dec_op  = DEC_LOAD_T;
        state_nxt   = S_E3;
      end
      S_E3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ASQ_BSQ;
        cmd.dec_op  = DEC_ADD_4T;
        state_nxt   = S_E4;
      end
      S_E4: begin
        cmd.dec_op = DEC_SUB_4T;
        state_nxt  = S_A3;
      end
      S_A4: begin
        if (out_free) begin
          cmd.dec_op = DEC_ADD_DELTA;
          cmd.step   = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mer_out.sv
`default_nettype none

module mer_out import mer_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  res_t    res_in,
  output logic    out_free,
  output logic    out_tvalid,
  input  logic    out_tready,
  output res_t    res_out
);

  logic valid_r;
  res_t res_r;

  // Hold the result until the downstream side takes the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_zero) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      res_r <= '0;
    end else if (cmd.emit) begin
      res_r <= res_in;
    end
  end

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign res_out    = res_r;

endmodule

`default_nettype wire

// File: hdl/midpoint_ellipse_rasterizer.sv
`default_nettype none

// Midpoint ellipse rasterizer, one quadrant mirrored four ways. A start request
// (tuser 0) loads semi-axes, center and color and returns the point (0, b); each
// advance request (tuser 1) returns the next point as the four mirrored
// coordinates, saturated to 16 bits, with tlast set on the point where y reaches
// zero, after which the ellipse ends. An advance with no ellipse running returns
// an all-zero result with tuser (valid_res) low. Every request gives exactly one
// result. One request is worked at a time: a start runs through the states ST1
// to ST4 and a normal advance through A1 to A4, while the single advance that
// crosses from region one to region two also runs E1 to E4 and returns to A3.
// The states follow the products on the one shared multiplier (each product
// is registered before it is used). A finished result sits in an output
// register, so a new request is taken while it waits; the block only stalls
// when a second result is ready before the first has left.

module midpoint_ellipse_rasterizer import mer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // semi_axis_x, semi_axis_y, center_x, center_y, color, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // x_plus, x_minus, y_plus, y_minus, pixel_color
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int AY_LO = AXIS_BITS;
  localparam int CX_LO = 2 * AXIS_BITS;
  localparam int CY_LO = CX_LO + COORD_BITS;
  localparam int CO_LO = CY_LO + COORD_BITS;

  in_item_t   item;
  dp_cmd_t    cmd;
  dp_status_t status;
  res_t       res_nxt, res_q;
  logic       out_free;

  // Unpack the request
  assign item.semi_axis_x = in_tdata[AXIS_BITS-1:0];
  assign item.semi_axis_y = in_tdata[AY_LO +: AXIS_BITS];
  assign item.center_x    = in_tdata[CX_LO +: COORD_BITS];
  assign item.center_y    = in_tdata[CY_LO +: COORD_BITS];
  assign item.color       = in_tdata[CO_LO +: COLOR_BITS];

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .status    (status),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  mer_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .res    (res_nxt)
  );

  mer_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .res_in     (res_nxt),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_out    (res_q)
  );

  // Pack the result
  assign out_tdata = OUT_DATA_W'({res_q.pixel_color, res_q.y_minus, res_q.y_plus,
                                  res_q.x_minus, res_q.x_plus});
  assign out_tuser = res_q.valid_res;
  assign out_tlast = res_q.last;

endmodule

`default_nettype wire

// File: tb/sv/tb_midpoint_ellipse_rasterizer.sv
module tb_midpoint_ellipse_rasterizer;
  import mer_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1130;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 40;
  localparam int SCRIPT_LEN  = 24;

  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) <<< (COORD_BITS - 1));

  // One directed request and, where it is obvious, the point it must return
  typedef struct packed {
    op_t    op;
    axis_t  a;
    axis_t  b;
    coord_t cx;
    coord_t cy;
    color_t color;
    logic   typed;
    res_t   want;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // advance right after reset: empty result, payload ignored
    '{OP_ADVANCE, 11'd2047, 11'd2047, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, '0},
    // both axes zero: single point at the center, flagged last
    '{OP_START, 11'd0, 11'd0, 16'd100, 16'hFF38, 24'hFFFFFF, 1'b1,
      '{16'd100, 16'd100, 16'hFF38, 16'hFF38, 24'hFFFFFF, 1'b1, 1'b1}},
    // advance after the last point: empty result
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b1, '0},
    // small ellipse through both regions and past its end
    '{OP_START, 11'd3, 11'd2, 16'd0, 16'd0, 24'h123456, 1'b1,
      '{16'd0, 16'd0, 16'd2, 16'hFFFE, 24'h123456, 1'b1, 1'b0}},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    // zero horizontal axis at the negative corner: straight into region two
    '{OP_START, 11'd0, 11'd3, 16'h8000, 16'h8000, 24'h000000, 1'b1,
      '{16'h8000, 16'h8000, 16'h8003, 16'h8000, 24'h000000, 1'b1, 1'b0}},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    // widest flat ellipse at the positive corner: y_plus saturates
    '{OP_START, 11'd2047, 11'd1, 16'h7FFF, 16'h7FFF, 24'hA5A5A5, 1'b1,
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFE, 24'hA5A5A5, 1'b1, 1'b0}},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    // start while busy: drop the running ellipse
    '{OP_START, 11'd1, 11'd2047, 16'd0, 16'd0, 24'h000001, 1'b1,
      '{16'd0, 16'd0, 16'd2047, 16'hF801, 24'h000001, 1'b1, 1'b0}},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    // both axes at their maximum
    '{OP_START, 11'd2047, 11'd2047, 16'hFFFF, 16'd1, 24'h800000, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'h0800, 16'hF802, 24'h800000, 1'b1, 1'b0}},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 11'd0, 11'd0, 16'd0, 16'd0, 24'h0, 1'b0, '0},
    // zero vertical axis while busy: last at once
    '{OP_START, 11'd5, 11'd0, 16'h8000, 16'h7FFF, 24'h00FF00, 1'b1,
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h00FF00, 1'b1, 1'b1}}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  midpoint_ellipse_rasterizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Shadow of the rasterizer state
  bit                ell_busy;
  bit                ell_region_two;
  bit [STEP_X_W-1:0] ell_x;
  bit [STEP_X_W-1:0] ell_y;
  bit [63:0]         ell_dec;
  bit [63:0]         ell_asq;
  bit [63:0]         ell_bsq;
  longint            ell_cx;
  longint            ell_cy;
  color_t            ell_color;

  res_t   pending_points [$];
  res_t   want_pt;
  res_t   got_pt;
  int     mismatches  = 0;
  int     points_seen = 0;
  int     sent        = 0;
  int     cycles      = 0;
  bit     steady      = 1'b0;

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_HI) return coord_t'(COORD_HI);
    if (v < COORD_LO) return coord_t'(COORD_LO);
    return coord_t'(v);
  endfunction

  // Mirror the current step about the center; end the ellipse at y == 0
  function automatic res_t emit_point();
    res_t r;
    r.x_plus      = clamp_coord(ell_cx + longint'(ell_x));
    r.x_minus     = clamp_coord(ell_cx - longint'(ell_x));
    r.y_plus      = clamp_coord(ell_cy + longint'(ell_y));
    r.y_minus     = clamp_coord(ell_cy - longint'(ell_y));
    r.pixel_color = ell_color;
    r.valid_res   = 1'b1;
    r.last        = (ell_y == 0);
    if (ell_y == 0) ell_busy = 1'b0;
    return r;
  endfunction

  // Advance the shadow by one request and return the point it yields
  function automatic res_t next_point(op_t op, in_item_t it);
    bit [63:0] a2, b2, x, y, prev;
    if (op == OP_START) begin
      a2             = 64'(it.semi_axis_x);
      b2             = 64'(it.semi_axis_y);
      ell_asq        = a2 * a2;
      ell_bsq        = b2 * b2;
      ell_cx         = longint'(it.center_x);
      ell_cy         = longint'(it.center_y);
      ell_color      = it.color;
      ell_x          = '0;
      ell_y          = STEP_X_W'(it.semi_axis_y);
      ell_region_two = 1'b0;
      ell_dec        = 4 * ell_bsq + ell_asq - 4 * ell_asq * b2;
      ell_busy       = 1'b1;
      return emit_point();
    end
    if (!ell_busy || ell_y == 0) begin
      ell_busy = 1'b0;
      return '0;
    end
    a2 = ell_asq;
    b2 = ell_bsq;
    x  = 64'(ell_x);
    y  = 64'(ell_y);
    if (!ell_region_two) begin
      if (2 * b2 * (x + 1) < a2 * (2 * y - 1)) begin
        prev    = ell_dec;
        ell_dec = ell_dec + 4 * b2 * (2 * x + 3);
        if (!prev[63]) begin
          ell_dec = ell_dec - 8 * a2 * (y - 1);
          ell_y--;
        end
        if (ell_x != '1) ell_x++;
        return emit_point();
      end
      // crossover: reseed the decision and fall into the region-two step
      ell_region_two = 1'b1;
      ell_dec = b2 * (2 * x + 1) * (2 * x + 1) + 4 * a2 * (y - 1) * (y - 1) - 4 * a2 * b2;
    end
    if (ell_dec[63]) begin
      ell_dec = ell_dec + 4 * b2 * (2 * x + 2) + 12 * a2 - 8 * a2 * y;
      if (ell_x != '1) ell_x++;
    end else begin
      ell_dec = ell_dec + 12 * a2 - 8 * a2 * y;
    end
    ell_y--;
    return emit_point();
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = IN_FIELDS_W'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic coord_t random_center();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) return coord_t'(COORD_HI - $urandom_range(0, 2500));
    if (pick < 24) return coord_t'(COORD_LO + $urandom_range(0, 2500));
    return coord_t'($urandom);
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at point %0d: %s", points_seen, what);
    mismatches++;
  endtask

  // Drive one request, hold it until taken, then log the point it must give
  task automatic send_request(op_t op, in_item_t it, bit typed, res_t want);
    res_t pt;
    if (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, it.color, it.center_y, it.center_x,
                  it.semi_axis_y, it.semi_axis_x};
    do @(posedge clk); while (!in_tready);
    pt = next_point(op, it);
    pending_points.push_back(typed ? want : pt);
    sent++;
  endtask

  // Output side: random backpressure, check each accepted point in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_pt.x_plus      = out_tdata[0 +: COORD_BITS];
        got_pt.x_minus     = out_tdata[COORD_BITS +: COORD_BITS];
        got_pt.y_plus      = out_tdata[2*COORD_BITS +: COORD_BITS];
        got_pt.y_minus     = out_tdata[3*COORD_BITS +: COORD_BITS];
        got_pt.pixel_color = out_tdata[4*COORD_BITS +: COLOR_BITS];
        got_pt.valid_res   = out_tuser;
        got_pt.last        = out_tlast;
        if (pending_points.size() == 0) begin
          flag_mismatch("point returned with nothing pending");
        end else begin
          want_pt = pending_points.pop_front();
          if (got_pt.x_plus !== want_pt.x_plus)
            flag_mismatch($sformatf("x_plus %0d, want %0d", got_pt.x_plus, want_pt.x_plus));
          if (got_pt.x_minus !== want_pt.x_minus)
            flag_mismatch($sformatf("x_minus %0d, want %0d", got_pt.x_minus, want_pt.x_minus));
          if (got_pt.y_plus !== want_pt.y_plus)
            flag_mismatch($sformatf("y_plus %0d, want %0d", got_pt.y_plus, want_pt.y_plus));
          if (got_pt.y_minus !== want_pt.y_minus)
            flag_mismatch($sformatf("y_minus %0d, want %0d", got_pt.y_minus, want_pt.y_minus));
          if (got_pt.pixel_color !== want_pt.pixel_color)
            flag_mismatch($sformatf("pixel_color %h, want %h",
                                    got_pt.pixel_color, want_pt.pixel_color));
          if (got_pt.valid_res !== want_pt.valid_res)
            flag_mismatch($sformatf("valid_res %b, want %b", got_pt.valid_res, want_pt.valid_res));
          if (got_pt.last !== want_pt.last)
            flag_mismatch($sformatf("last %b, want %b", got_pt.last, want_pt.last));
        end
        points_seen++;
      end
      out_tready <= steady || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    int unsigned size_pick;
    int unsigned adv_limit;
    int unsigned adv_count;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      it.semi_axis_x = SCRIPT[i].a;
      it.semi_axis_y = SCRIPT[i].b;
      it.center_x    = SCRIPT[i].cx;
      it.center_y    = SCRIPT[i].cy;
      it.color       = SCRIPT[i].color;
      send_request(SCRIPT[i].op, it, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Random ellipses: mostly small and run to the end, large ones cut short
    while (sent < SCRIPT_LEN + RAND_ITEMS) begin
      steady    = (sent >= 400 && sent < 650);
      it        = random_item();
      size_pick = $urandom_range(99);
      if (size_pick < 70) begin
        it.semi_axis_x = axis_t'($urandom_range(0, 15));
        it.semi_axis_y = axis_t'($urandom_range(0, 15));
        adv_limit = ($urandom_range(99) < 15) ? $urandom_range(1, 10) : 32'hFFFF;
      end else if (size_pick < 88) begin
        it.semi_axis_x = axis_t'($urandom_range(0, 90));
        it.semi_axis_y = axis_t'($urandom_range(0, 90));
        adv_limit = ($urandom_range(99) < 50) ? $urandom_range(1, 40) : 32'hFFFF;
      end else begin
        adv_limit = $urandom_range(1, 20);
      end
      it.center_x = random_center();
      it.center_y = random_center();
      send_request(OP_START, it, 1'b0, '0);

      adv_count = 0;
      while (ell_busy && adv_count < adv_limit) begin
        send_request(OP_ADVANCE, random_item(), 1'b0, '0);
        adv_count++;
      end

      // stray advances with no ellipse running
      if (!ell_busy && $urandom_range(99) < 20)
        repeat ($urandom_range(1, 2)) send_request(OP_ADVANCE, random_item(), 1'b0, '0);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mer_pkg.sv
hdl/mer_dp.sv
hdl/mer_ctrl.sv
hdl/mer_out.sv
hdl/midpoint_ellipse_rasterizer.sv
tb/sv/tb_midpoint_ellipse_rasterizer.sv
